[hdl/irtp_pkg.sv]
// Shared constants and types for the three-phase IR frame receiver.
package irtp_pkg;

    localparam int FRAME_BITS = 16;
    localparam int BITS_W     = $clog2(FRAME_BITS + 1);
    localparam int TICKS_W    = 16;
    localparam int PHASE_W    = 2;
    localparam int PAT_W      = 3;

    localparam logic [TICKS_W-1:0] TICKS_RESET     = 16'd800;
    localparam logic [PHASE_W-1:0] SAMPLES_PER_BIT = 2'd3;
    localparam logic [PAT_W-1:0]   PAT_ONE         = 3'b110;
    localparam logic [PAT_W-1:0]   PAT_ZERO        = 3'b100;

    typedef struct packed {
        logic                  valid;
        logic [FRAME_BITS-1:0] data;
        logic                  bad;
    } irtp_result_t;

endpackage

[hdl/ir_three_phase_frame_receiver.sv]
// A result is registered when the beat that completes or aborts its frame is decoded.
// Throughput: one input beat per cycle; one beat is decoded per cycle by the frame logic.
// The input stage stalls only while a finished result waits for m_axis_tready.
// Reset clears the frame state, both pipeline stages and sets third_bit_ticks to 800.
// Top level: input register, frame decode, output register and configuration register.
module ir_three_phase_frame_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] line_level, [7:1] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] frame_data
    output logic        m_axis_tuser,   // [0] bad_bit
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    import irtp_pkg::*;

    logic                  in_valid_reg;
    logic                  in_level_reg;
    logic                  out_valid_reg;
    logic [FRAME_BITS-1:0] out_data_reg;
    logic                  out_bad_reg;
    logic [TICKS_W-1:0]    ticks_reg;
    logic                  advance;
    logic                  step;
    irtp_result_t          result;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    irtp_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .level           (in_level_reg),
        .third_bit_ticks (ticks_reg),
        .result          (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= TICKS_RESET;
        end
        else if (cfg_we)
        begin
            ticks_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_level_reg <= s_axis_tdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg && result.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && result.valid)
        begin
            out_data_reg <= result.data;
            out_bad_reg  <= result.bad;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_bad_reg;

`ifndef SYNTHESIS
    a_bad_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("aborted frame carries nonzero data");

    a_out_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step))
        else $error("result appeared without a decoded beat");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_level_reg)))
        else $error("input stage lost a beat while stalled");
`endif

endmodule

[hdl/irtp_core.sv]
// Frame state and per-beat decode: countdown, hunting, bit sampling and word assembly.
module irtp_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   level,
    input  logic [15:0]            third_bit_ticks,
    output irtp_pkg::irtp_result_t result
);
    import irtp_pkg::*;

    logic                  in_frame_reg, in_frame_next;
    logic [TICKS_W-1:0]    wait_reg, wait_next;
    logic [PHASE_W-1:0]    phase_reg, phase_next;
    logic [PAT_W-1:0]      pat_reg, pat_next;
    logic [BITS_W-1:0]     bits_reg, bits_next;
    logic [FRAME_BITS-1:0] word_reg, word_next;

    logic [TICKS_W-1:0]    third_wait;
    logic [TICKS_W-1:0]    half_ticks;
    logic [TICKS_W-1:0]    hunt_wait;
    logic [FRAME_BITS-1:0] shifted_word;
    logic [BITS_W-1:0]     bits_inc;
    logic                  pat_valid;

    assign third_wait   = (third_bit_ticks > 16'd1) ? third_bit_ticks - 16'd1 : '0;
    assign half_ticks   = third_bit_ticks >> 1;
    assign hunt_wait    = (half_ticks > 16'd1) ? half_ticks - 16'd1 : '0;
    assign pat_valid    = (pat_reg == PAT_ONE) || (pat_reg == PAT_ZERO);
    assign shifted_word = {word_reg[FRAME_BITS-2:0], pat_reg == PAT_ONE};
    assign bits_inc     = bits_reg + 1'b1;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        wait_next     = wait_reg;
        phase_next    = phase_reg;
        pat_next      = pat_reg;
        bits_next     = bits_reg;
        word_next     = word_reg;
        result        = '0;

        if (wait_reg != '0)
        begin
            wait_next = wait_reg - 1'b1;
        end
        else if (in_frame_reg && (phase_reg != SAMPLES_PER_BIT))
        begin
            pat_next   = {pat_reg[PAT_W-2:0], level};
            phase_next = phase_reg + 1'b1;
            wait_next  = third_wait;
        end
        else if (in_frame_reg && pat_valid &&
                 (bits_inc != BITS_W'(FRAME_BITS)))
        begin
            // Bit accepted and more to come: this beat is the first sample of the next bit.
            word_next  = shifted_word;
            bits_next  = bits_inc;
            pat_next   = {{(PAT_W-1){1'b0}}, level};
            phase_next = 2'd1;
            wait_next  = third_wait;
        end
        else
        begin
            // Hunting check; a finished or aborted frame also checks on this same beat.
            if (in_frame_reg)
            begin
                result.valid = 1'b1;
                result.bad   = !pat_valid;
                result.data  = pat_valid ? shifted_word : '0;
                word_next    = shifted_word;
                bits_next    = bits_inc;
            end
            if (level)
            begin
                in_frame_next = 1'b1;
                bits_next     = '0;
                word_next     = '0;
                pat_next      = {{(PAT_W-1){1'b0}}, 1'b1};
                phase_next    = 2'd1;
                wait_next     = third_wait;
            end
            else
            begin
                in_frame_next = 1'b0;
                wait_next     = hunt_wait;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            wait_reg     <= '0;
            phase_reg    <= '0;
            pat_reg      <= '0;
            bits_reg     <= '0;
            word_reg     <= '0;
        end
        else if (step)
        begin
            in_frame_reg <= in_frame_next;
            wait_reg     <= wait_next;
            phase_reg    <= phase_next;
            pat_reg      <= pat_next;
            bits_reg     <= bits_next;
            word_reg     <= word_next;
        end
    end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for the three-phase IR frame receiver: directed frames, then random traffic.
module tb_top;
    import irtp_pkg::*;

    localparam int KEEP_TICKS   = -1;
    localparam int NO_BAD_BIT   = -1;
    localparam int IDLE_LIMIT   = 20000;
    localparam int RANDOM_ITEMS = 360;
    localparam int HOLD_CYCLES  = 600;
    localparam int HOLD_AFTER   = 800;
    localparam int PIPE_CYCLES  = 4;

    typedef struct packed {
        logic [FRAME_BITS-1:0] data;
        logic                  bad;
    } frame_result_t;

    typedef struct {
        int                    ticks;
        logic [31:0]           bits;
        int                    nbits;
        int                    bad_at;
        logic [PAT_W-1:0]      bad_pat;
        bit                    typed;
        logic [FRAME_BITS-1:0] exp_data;
        bit                    exp_bad;
    } frame_case_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [0] line_level, [7:1] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [15:0] frame_data
    logic        m_axis_tuser;   // [0] bad_bit
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    ir_three_phase_frame_receiver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    // Bad-pattern rows list the first result only; whatever the leftover bits decode to is
    // left to the decoder model.
    frame_case_t frame_cases [14] = '{
        '{1,          32'h0000_A5C3, 16, NO_BAD_BIT, 3'b000, 1'b1, 16'hA5C3, 1'b0},
        '{KEEP_TICKS, 32'h0000_FFFF, 16, NO_BAD_BIT, 3'b000, 1'b1, 16'hFFFF, 1'b0},
        '{0,          32'h0000_0000, 16, NO_BAD_BIT, 3'b000, 1'b1, 16'h0000, 1'b0},
        '{2,          32'h0000_8001, 16, NO_BAD_BIT, 3'b000, 1'b1, 16'h8001, 1'b0},
        '{3,          32'h0000_5555, 16, NO_BAD_BIT, 3'b000, 1'b1, 16'h5555, 1'b0},
        '{2,          32'h0000_FFFF, 16, 15,         3'b000, 1'b1, 16'h0000, 1'b1},
        '{3,          32'h0000_1234, 16, 15,         3'b001, 1'b1, 16'h0000, 1'b1},
        '{4,          32'h0000_BEEF, 16, 7,          3'b010, 1'b1, 16'h0000, 1'b1},
        '{1,          32'h0000_0F0F, 16, 0,          3'b111, 1'b1, 16'h0000, 1'b1},
        '{2,          32'h0000_F0F0, 16, 0,          3'b101, 1'b1, 16'h0000, 1'b1},
        '{3,          32'h0000_7E81, 16, 3,          3'b011, 1'b1, 16'h0000, 1'b1},
        '{1,          32'h000C_3A5F, 20, NO_BAD_BIT, 3'b000, 1'b0, 16'h0000, 1'b0},
        '{5,          32'h0000_0015, 5,  NO_BAD_BIT, 3'b000, 1'b0, 16'h0000, 1'b0},
        '{1,          32'h2468_ACE1, 32, NO_BAD_BIT, 3'b000, 1'b0, 16'h0000, 1'b0}
    };

    // Decoder model state.
    logic [TICKS_W-1:0]    cfg_third   = TICKS_RESET;
    bit                    rx_active   = 1'b0;
    logic [TICKS_W-1:0]    countdown   = '0;
    logic [PHASE_W-1:0]    phase       = '0;
    logic [PAT_W-1:0]      pat         = '0;
    logic [BITS_W-1:0]     nbits       = '0;
    logic [FRAME_BITS-1:0] word        = '0;

    frame_result_t expected_frames[$];
    frame_result_t typed_value;
    bit            typed_pending = 1'b0;
    int            burst_left    = 0;
    int            items_sent    = 0;
    int            results_predicted = 0;
    int            results_checked   = 0;
    int            frames_ok     = 0;
    int            frames_bad    = 0;
    int            settings_used = 0;
    int            error_count   = 0;

    function automatic void take_sample(input bit lvl);
        pat       = {pat[PAT_W-2:0], lvl};
        phase     = phase + 1'b1;
        countdown = (cfg_third > 1) ? cfg_third - 1'b1 : '0;
    endfunction

    function automatic void hunt_check(input bit lvl);
        logic [TICKS_W-1:0] half;
        half = cfg_third >> 1;
        if (lvl)
        begin
            rx_active = 1'b1;
            nbits     = '0;
            word      = '0;
            pat       = '0;
            phase     = '0;
            take_sample(lvl);
        end
        else
        begin
            rx_active = 1'b0;
            countdown = (half > 1) ? half - 1'b1 : '0;
        end
    endfunction

    // Advances the decoder by one line sample; returns 1 when a result leaves on this tick.
    function automatic bit decode_tick(input bit lvl, output frame_result_t res);
        res = '0;
        if (countdown != 0)
        begin
            countdown = countdown - 1'b1;
            return 1'b0;
        end
        if (!rx_active)
        begin
            hunt_check(lvl);
            return 1'b0;
        end
        if (phase >= SAMPLES_PER_BIT)
        begin
            if (pat == PAT_ONE || pat == PAT_ZERO)
            begin
                word  = {word[FRAME_BITS-2:0], pat == PAT_ONE};
                nbits = nbits + 1'b1;
                if (nbits >= FRAME_BITS)
                begin
                    res.data = word;
                    res.bad  = 1'b0;
                    hunt_check(lvl);
                    return 1'b1;
                end
                phase = '0;
                pat   = '0;
            end
            else
            begin
                res.data = '0;
                res.bad  = 1'b1;
                hunt_check(lvl);
                return 1'b1;
            end
        end
        take_sample(lvl);
        return 1'b0;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offers one line sample and waits for its beat; the sender works in bursts.
    task automatic push_level(input bit lvl);
        int            gap;
        frame_result_t res;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 500 : $urandom_range(1, 64);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, lvl};
        do @(posedge clk); while (!s_axis_tready);
        burst_left--;
        items_sent++;
        if (decode_tick(lvl, res))
        begin
            if (res.bad)
                frames_bad++;
            else
                frames_ok++;
            if (typed_pending)
            begin
                res = typed_value;
                typed_pending = 1'b0;
            end
            expected_frames.push_back(res);
            results_predicted++;
        end
    endtask

    // Lets every expected result out, then gives the pipeline time to empty.
    task automatic settle_outputs();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_frames.size() != 0) @(posedge clk);
        repeat (PIPE_CYCLES) @(posedge clk);
    endtask

    task automatic retune(input logic [TICKS_W-1:0] ticks);
        settle_outputs();
        cfg_we    <= 1'b1;
        cfg_wdata <= ticks;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_third = ticks;
        settings_used++;
    endtask

    // Drives an IR waveform: each bit is three thirds, MSB first, then a low tail long
    // enough for the decoder to finish or abort.
    task automatic send_frame(input logic [31:0] bits, input int count, input int bad_at,
                              input logic [PAT_W-1:0] bad_pat, input int lead);
        int               tw;
        logic [PAT_W-1:0] wave;
        tw = (cfg_third > 1) ? int'(cfg_third) : 1;
        repeat (lead) push_level(1'b0);
        for (int k = 0; k < count; k++)
        begin
            wave = bits[count-1-k] ? PAT_ONE : PAT_ZERO;
            if (k == bad_at)
                wave = bad_pat;
            for (int j = PAT_W - 1; j >= 0; j--)
                repeat (tw) push_level(wave[j]);
        end
        repeat (3 * tw + 2) push_level(1'b0);
    endtask

    always @(posedge clk)
    begin
        frame_result_t exp_res;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_checked++;
            if (expected_frames.size() == 0)
            begin
                $error("result beat with nothing expected: frame_data=%h bad_bit=%b",
                       m_axis_tdata, m_axis_tuser);
                error_count++;
            end
            else
            begin
                exp_res = expected_frames.pop_front();
                if (m_axis_tdata !== exp_res.data)
                begin
                    $error("frame_data: expected %h, actual %h", exp_res.data, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tuser !== exp_res.bad)
                begin
                    $error("bad_bit: expected %b, actual %b", exp_res.bad, m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    // Receiver: segments of steady or random readiness, with a long hold-off now and then.
    initial
    begin
        int seg;
        int mode;
        int since_hold;
        since_hold = 0;
        m_axis_tready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            seg  = $urandom_range(20, 200);
            mode = $urandom_range(0, 3);
            if (since_hold > HOLD_AFTER)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                since_hold = 0;
            end
            else
            begin
                repeat (seg)
                begin
                    m_axis_tready <= (mode == 0) ? 1'b1 : ($urandom_range(0, mode) != 0);
                    @(posedge clk);
                    since_hold++;
                end
            end
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
                idle = 0;
            else
                idle++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int               base;
        int               kind;
        int               bad_at;
        logic [PAT_W-1:0] bad_pat;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        rst_n         <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (frame_cases[i])
        begin
            if (frame_cases[i].ticks != KEEP_TICKS)
                retune(16'(frame_cases[i].ticks));
            typed_pending = frame_cases[i].typed;
            typed_value   = '{frame_cases[i].exp_data, frame_cases[i].exp_bad};
            send_frame(frame_cases[i].bits, frame_cases[i].nbits, frame_cases[i].bad_at,
                       frame_cases[i].bad_pat, 2);
            typed_pending = 1'b0;
        end

        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 6)
                retune(16'($urandom_range(0, 5)));
            else if (kind < 8)
                retune(16'($urandom_range(6, 9)));
            else if (kind == 8)
                retune(16'd2);
            else
                retune(16'($urandom_range(10, 14)));
            repeat ($urandom_range(2, 4))
            begin
                if (items_sent - base >= RANDOM_ITEMS)
                    break;
                kind = $urandom_range(0, 19);
                if (kind < 14)
                    send_frame($urandom(), FRAME_BITS, NO_BAD_BIT, '0, $urandom_range(0, 12));
                else if (kind < 16)
                begin
                    bad_at = $urandom_range(0, FRAME_BITS - 1);
                    do bad_pat = PAT_W'($urandom_range(0, 7));
                    while (bad_pat == PAT_ONE || bad_pat == PAT_ZERO);
                    send_frame($urandom(), FRAME_BITS, bad_at, bad_pat, $urandom_range(0, 12));
                end
                else if (kind == 16)
                    send_frame($urandom(), $urandom_range(FRAME_BITS + 1, 24), NO_BAD_BIT, '0,
                               $urandom_range(0, 12));
                else if (kind == 17)
                    send_frame($urandom(), $urandom_range(1, FRAME_BITS - 1), NO_BAD_BIT, '0,
                               $urandom_range(0, 12));
                else
                    repeat ($urandom_range(5, 60)) push_level($urandom_range(0, 1));
            end
        end

        settle_outputs();
        $display("Run covered %0d line samples over %0d third-bit settings, including 0, 1 and 2;",
                 items_sent, settings_used);
        $display("%0d results checked (%0d complete frames, %0d aborted frames).",
                 results_checked, frames_ok, frames_bad);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[filelist.f]
hdl/irtp_pkg.sv
hdl/irtp_core.sv
hdl/ir_three_phase_frame_receiver.sv
bench/tb_top.sv
